### rtl/switch_debounce_tap_tempo_defines.svh
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SWITCH_DEBOUNCE_TAP_TEMPO_DEFINES_SVH
`define SWITCH_DEBOUNCE_TAP_TEMPO_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define SWDB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SWDB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/swdb_pkg.sv
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: package
// Widths, coefficients, register map and shared structures.
// ----------------------------------------------------------------------------
package swdb_pkg;

    // Width of the interval and hold counters (8 to 32).
    localparam int TICK_BITS = 24;
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    localparam int DELAY_W   = 16;
    localparam int PERIOD_W  = 24;
    localparam int AVG_W     = 32;
    localparam int COUNT_W   = 16;
    localparam int HOLD_W    = 24;
    localparam int COEF_W    = 16;

    // Q0.16 coefficients of the moving average and of the clamp window.
    localparam logic [COEF_W-1:0] ALPHA_Q16 = 16'd13107;
    localparam logic [COEF_W-1:0] BETA_Q16  = 16'd52429;
    localparam logic [COEF_W-1:0] SPAN_Q16  = 16'd9830;

    localparam int P_W     = TICK_BITS + 8;
    localparam int PP_W    = P_W + COEF_W;
    localparam int AP_W    = AVG_W + COEF_W;
    localparam int SUM_W   = ((PP_W > AP_W) ? PP_W : AP_W) + 1;
    localparam int NV_W    = SUM_W - COEF_W;
    localparam int CMP_W   = (NV_W > P_W) ? NV_W : P_W;
    localparam int CNT_CMP_W = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_RELEASE_DELAY = 2'd0,
        REG_MIN_TAP       = 2'd1,
        REG_MAX_TAP       = 2'd2,
        REG_ABORT         = 2'd3
    } swdb_reg_t;

    localparam logic [DELAY_W-1:0]  RST_RELEASE_DELAY = 16'd10;
    localparam logic [PERIOD_W-1:0] RST_MIN_TAP       = 24'd100;
    localparam logic [PERIOD_W-1:0] RST_MAX_TAP       = 24'd4000;
    localparam logic [PERIOD_W-1:0] RST_ABORT         = 24'd6000;

    typedef struct packed {
        logic [DELAY_W-1:0]  release_delay;
        logic [PERIOD_W-1:0] min_tap;
        logic [PERIOD_W-1:0] max_tap;
        logic [PERIOD_W-1:0] abort_period;
    } swdb_cfg_t;

    typedef struct packed {
        logic               pressed;
        logic [HOLD_W-1:0]  hold_ticks;
        logic [COUNT_W-1:0] press_total;
        logic [AVG_W-1:0]   tempo_average;
        logic [COUNT_W-1:0] tempo_updates;
        logic               stopped;
    } swdb_result_t;

endpackage

### rtl/swdb_cfg.sv
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: configuration registers
// APB-style register file holding the debounce and tempo settings.
// ----------------------------------------------------------------------------
module swdb_cfg
    import swdb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output swdb_cfg_t         cfg
);

    swdb_cfg_t cfg_reg;
    swdb_reg_t reg_sel;
    logic      wr_en;

    assign reg_sel = swdb_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.release_delay <= RST_RELEASE_DELAY;
            cfg_reg.min_tap       <= RST_MIN_TAP;
            cfg_reg.max_tap       <= RST_MAX_TAP;
            cfg_reg.abort_period  <= RST_ABORT;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_RELEASE_DELAY: cfg_reg.release_delay <= pwdata[DELAY_W-1:0];
                REG_MIN_TAP:       cfg_reg.min_tap       <= pwdata[PERIOD_W-1:0];
                REG_MAX_TAP:       cfg_reg.max_tap       <= pwdata[PERIOD_W-1:0];
                REG_ABORT:         cfg_reg.abort_period  <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_RELEASE_DELAY: prdata = DATA_W'(cfg_reg.release_delay);
            REG_MIN_TAP:       prdata = DATA_W'(cfg_reg.min_tap);
            REG_MAX_TAP:       prdata = DATA_W'(cfg_reg.max_tap);
            REG_ABORT:         prdata = DATA_W'(cfg_reg.abort_period);
            default:           prdata = '0;
        endcase
    end

endmodule

### rtl/swdb_core.sv
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: tick engine
// Debounce state, counters and the tap-tempo moving average, one tick per item.
// ----------------------------------------------------------------------------
module swdb_core
    import swdb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         tick_en,
    input  logic         pin_level,
    input  swdb_cfg_t    cfg,
    output swdb_result_t result_next
);

    logic                 sw_reg, sw_next;
    logic [TICK_BITS-1:0] hold_reg, hold_next;
    logic [COUNT_W-1:0]   press_reg, press_next;
    logic [TICK_BITS-1:0] ival_reg, ival_next;
    logic [AVG_W-1:0]     avg_reg, avg_next;
    logic [COUNT_W-1:0]   upd_reg, upd_next;
    logic                 stop_reg, stop_next;
    logic                 rc_act_reg, rc_act_next;
    logic [DELAY_W-1:0]   rc_reg, rc_next;

    logic [TICK_BITS-1:0] ival_inc;
    logic [CNT_CMP_W-1:0] ival_cmp;
    logic [CNT_CMP_W-1:0] hold_ext;
    logic                 abort_hit;
    logic [AVG_W-1:0]     avg_a;
    logic [COUNT_W-1:0]   upd_a;

    logic [P_W-1:0]       p_val;
    logic [PP_W-1:0]      prod_p;
    logic [AP_W-1:0]      prod_a;
    logic [AP_W-1:0]      prod_span;
    logic [AVG_W:0]       lo_b, hi_b;
    logic [SUM_W-1:0]     sum;
    logic [CMP_W-1:0]     nv, nv_clamped;
    logic [AVG_W-1:0]     avg_tap;

    assign ival_inc  = (ival_reg == TICK_MAX) ? ival_reg : ival_reg + 1'b1;
    assign ival_cmp  = CNT_CMP_W'(ival_inc);
    assign abort_hit = ival_cmp > CNT_CMP_W'(cfg.abort_period);
    assign avg_a     = abort_hit ? '0 : avg_reg;
    assign upd_a     = abort_hit ? '0 : upd_reg;

    // Tap-tempo datapath: weighted sum, then clamp to 15 % around the old value once an average exists.
    assign p_val     = {ival_inc, 8'd0};
    assign prod_p    = PP_W'(p_val) * PP_W'(ALPHA_Q16);
    assign prod_a    = AP_W'(avg_a) * AP_W'(BETA_Q16);
    assign prod_span = AP_W'(avg_a) * AP_W'(SPAN_Q16);
    assign lo_b      = (AVG_W+1)'(avg_a) - (AVG_W+1)'(prod_span[AP_W-1:COEF_W]);
    assign hi_b      = (AVG_W+1)'(avg_a) + (AVG_W+1)'(prod_span[AP_W-1:COEF_W]);
    assign sum       = SUM_W'(prod_p) + SUM_W'(prod_a);

    always_comb begin
        if (upd_a != '0) begin
            nv = CMP_W'(sum[SUM_W-1:COEF_W]);
            if (nv < CMP_W'(lo_b)) begin
                nv = CMP_W'(lo_b);
            end
            if (nv > CMP_W'(hi_b)) begin
                nv = CMP_W'(hi_b);
            end
        end else begin
            nv = CMP_W'(p_val);
        end
        nv_clamped = nv;
        if (nv_clamped > CMP_W'({AVG_W{1'b1}})) begin
            avg_tap = {AVG_W{1'b1}};
        end else begin
            avg_tap = nv_clamped[AVG_W-1:0];
        end
    end

    always_comb begin
        sw_next     = sw_reg;
        hold_next   = hold_reg;
        press_next  = press_reg;
        ival_next   = ival_inc;
        avg_next    = avg_a;
        upd_next    = upd_a;
        stop_next   = abort_hit ? 1'b1 : stop_reg;
        rc_act_next = rc_act_reg;
        rc_next     = rc_reg;

        if (sw_reg && (hold_reg != TICK_MAX)) begin
            hold_next = hold_reg + 1'b1;
        end

        if (!pin_level) begin
            if (!sw_reg) begin
                sw_next    = 1'b1;
                hold_next  = '0;
                press_next = press_reg + 1'b1;
                if (stop_next) begin
                    // The first press after a stop only restarts the interval.
                    stop_next = 1'b0;
                    ival_next = '0;
                end else if ((ival_cmp > CNT_CMP_W'(cfg.min_tap)) &&
                             (ival_cmp < CNT_CMP_W'(cfg.max_tap))) begin
                    avg_next  = avg_tap;
                    upd_next  = (upd_a == '1) ? upd_a : upd_a + 1'b1;
                    ival_next = '0;
                end
            end
        end else if (sw_reg) begin
            // A press in between leaves a running countdown untouched.
            if (!rc_act_reg) begin
                rc_act_next = 1'b1;
                rc_next     = cfg.release_delay;
            end else if (rc_reg <= DELAY_W'(1)) begin
                sw_next     = 1'b0;
                rc_act_next = 1'b0;
                rc_next     = '0;
            end else begin
                rc_next = rc_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg     <= 1'b0;
            hold_reg   <= '0;
            press_reg  <= '0;
            ival_reg   <= '0;
            avg_reg    <= '0;
            upd_reg    <= '0;
            stop_reg   <= 1'b1;
            rc_act_reg <= 1'b0;
            rc_reg     <= '0;
        end else if (tick_en) begin
            sw_reg     <= sw_next;
            hold_reg   <= hold_next;
            press_reg  <= press_next;
            ival_reg   <= ival_next;
            avg_reg    <= avg_next;
            upd_reg    <= upd_next;
            stop_reg   <= stop_next;
            rc_act_reg <= rc_act_next;
            rc_reg     <= rc_next;
        end
    end

    assign hold_ext = CNT_CMP_W'(hold_next);

    assign result_next.pressed       = sw_next;
    assign result_next.hold_ticks    = hold_ext[HOLD_W-1:0];
    assign result_next.press_total   = press_next;
    assign result_next.tempo_average = avg_next;
    assign result_next.tempo_updates = upd_next;
    assign result_next.stopped       = stop_next;

endmodule

### rtl/swdb_out.sv
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: result register
// Holds one finished item for the output channel and drives the input ready.
// ----------------------------------------------------------------------------
module swdb_out
    import swdb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  swdb_result_t result_next,
    output logic         out_valid,
    input  logic         out_ready,
    output swdb_result_t result
);

    logic         valid_reg;
    swdb_result_t data_reg;

    // A held item that is being taken this cycle makes room for the next one.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= result_next;
        end
    end

endmodule

### rtl/switch_debounce_tap_tempo.sv
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: top level
// Debounces an active-low switch and tracks the tap tempo, one tick per item.
//
//   Channel     Direction   Handshake                Carries
//   s_axis      in          s_tvalid / s_tready      one tick with the raw pin level
//   m_axis      out         m_tvalid / m_tready      switch and tempo state after it
//   APB         in          psel, penable, pready    four settings registers
//
// One item is taken per cycle while the output is not stalled; its result is in
// the output register the cycle after, captured when the item is accepted.
// The multiply-add and clamp of the tempo average form the combinational path.
// Reset is synchronous and active low; it returns the settings to defaults.
// A stalled output holds its item, and no input is taken until it is accepted.
// ----------------------------------------------------------------------------
module switch_debounce_tap_tempo
    import swdb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] pin_level, [7:1] zero
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,   // [0] pressed, [24:1] hold_ticks,
                                         // [40:25] press_total,
                                         // [72:41] tempo_average,
                                         // [88:73] tempo_updates,
                                         // [89] stopped, [95:90] zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    swdb_cfg_t    cfg;
    swdb_result_t result_next;
    swdb_result_t result;
    logic         tick_en;

    assign pready  = 1'b1;
    assign tick_en = s_tvalid && s_tready;

    swdb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    swdb_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (tick_en),
        .pin_level   (s_tdata[0]),
        .cfg         (cfg),
        .result_next (result_next)
    );

    swdb_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .result_next (result_next),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result)
    );

    assign m_tdata = {6'd0,
                      result.stopped,
                      result.tempo_updates,
                      result.tempo_average,
                      result.press_total,
                      result.hold_ticks,
                      result.pressed};

endmodule

### rtl/swdb_checker.sv
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: port checker
// Watches the top-level ports for handshake and tempo state consistency.
// ----------------------------------------------------------------------------
`include "switch_debounce_tap_tempo_defines.svh"

module swdb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // A stalled result item must keep its contents.
    `SWDB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

    // With the output register empty, the block must take input.
    `SWDB_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input not ready with empty output register")

    // A result only appears after an input item was accepted.
    `SWDB_ASSERT_IMP(a_result_source, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready), "result item without an accepted input item")

    // While stopped, the tempo average and its update count are clear.
    `SWDB_ASSERT_IMP(a_stopped_clear, aclk, aresetn, m_tvalid && m_tdata[89], (m_tdata[72:41] == 32'd0) && (m_tdata[88:73] == 16'd0), "tempo state not cleared while stopped")

endmodule

bind switch_debounce_tap_tempo swdb_checker u_swdb_checker (.*);

### tb/switch_debounce_tap_tempo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Switch debounce tap tempo: testbench
// Feeds tick items carrying the raw pin level, short directed runs first and
// then random taps, bounces and long silences under several settings. A
// scoreboard predicts the debounced state and the tap tempo average for every
// item and checks each result field by field.
// ----------------------------------------------------------------------------
module switch_debounce_tap_tempo_tb;
    import swdb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    class tempo_scoreboard;
        logic [DELAY_W-1:0]   release_delay;
        logic [PERIOD_W-1:0]  min_tap;
        logic [PERIOD_W-1:0]  max_tap;
        logic [PERIOD_W-1:0]  abort_ticks;

        logic                 switch_down;
        logic [TICK_BITS-1:0] hold_cnt;
        logic [COUNT_W-1:0]   press_cnt;
        logic [TICK_BITS-1:0] interval_cnt;
        logic [AVG_W-1:0]     avg_period;
        logic [COUNT_W-1:0]   update_cnt;
        logic                 stop_flag;
        bit                   countdown_on;
        logic [16:0]          countdown;

        swdb_result_t         expected_q[$];
        int unsigned          errors;

        function new();
            release_delay = RST_RELEASE_DELAY;
            min_tap       = RST_MIN_TAP;
            max_tap       = RST_MAX_TAP;
            abort_ticks   = RST_ABORT;
            switch_down   = 1'b0;
            hold_cnt      = '0;
            press_cnt     = '0;
            interval_cnt  = '0;
            avg_period    = '0;
            update_cnt    = '0;
            stop_flag     = 1'b1;
            countdown_on  = 1'b0;
            countdown     = '0;
            errors        = 0;
        endfunction

        function void configure(input swdb_reg_t which, input logic [DATA_W-1:0] value);
            case (which)
                REG_RELEASE_DELAY: release_delay = value[DELAY_W-1:0];
                REG_MIN_TAP:       min_tap       = value[PERIOD_W-1:0];
                REG_MAX_TAP:       max_tap       = value[PERIOD_W-1:0];
                REG_ABORT:         abort_ticks   = value[PERIOD_W-1:0];
            endcase
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Folds the current interval into the average, clamped to within 15% of the old value once an average exists.
        function void fold_interval();
            logic [63:0] p, a, span, lo, hi, nv;
            p = 64'(interval_cnt) << 8;
            if (update_cnt != '0) begin
                a    = 64'(avg_period);
                span = (a * 64'(SPAN_Q16)) >> 16;
                lo   = a - span;
                hi   = a + span;
                nv   = (p * 64'(ALPHA_Q16) + a * 64'(BETA_Q16)) >> 16;
                if (nv < lo) nv = lo;
                if (nv > hi) nv = hi;
            end else begin
                nv = p;
            end
            avg_period   = (nv > 64'hFFFF_FFFF) ? '1 : nv[AVG_W-1:0];
            update_cnt   = (update_cnt == '1) ? update_cnt : update_cnt + 1'b1;
            interval_cnt = '0;
        endfunction

        function void note_tick(input logic pin);
            swdb_result_t r;
            if (interval_cnt != TICK_MAX) interval_cnt++;
            if (switch_down && hold_cnt != TICK_MAX) hold_cnt++;

            if (interval_cnt > abort_ticks) begin
                update_cnt = '0;
                avg_period = '0;
                stop_flag  = 1'b1;
            end

            if (!pin) begin
                if (!switch_down) begin
                    switch_down = 1'b1;
                    hold_cnt    = '0;
                    press_cnt++;
                    if (stop_flag) begin
                        stop_flag    = 1'b0;
                        interval_cnt = '0;
                    end
                    if (interval_cnt > min_tap && interval_cnt < max_tap) fold_interval();
                end
            end else if (switch_down) begin
                // The countdown is neither cancelled nor reloaded by a press.
                if (!countdown_on) begin
                    countdown_on = 1'b1;
                    countdown    = 17'(release_delay);
                end else if (countdown <= 17'd1) begin
                    switch_down  = 1'b0;
                    countdown_on = 1'b0;
                    countdown    = '0;
                end else begin
                    countdown--;
                end
            end

            r.pressed       = switch_down;
            r.hold_ticks    = hold_cnt[HOLD_W-1:0];
            r.press_total   = press_cnt;
            r.tempo_average = avg_period;
            r.tempo_updates = update_cnt;
            r.stopped       = stop_flag;
            expected_q.push_back(r);
        endfunction

        function void compare_field(input string field, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            end
        endfunction

        function void check_result(input logic [95:0] data);
            swdb_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $error("result item arrived with no expectation waiting");
                return;
            end
            want = expected_q.pop_front();
            compare_field("pressed", 32'(want.pressed), 32'(data[0]));
            compare_field("hold_ticks", 32'(want.hold_ticks), 32'(data[24:1]));
            compare_field("press_total", 32'(want.press_total), 32'(data[40:25]));
            compare_field("tempo_average", want.tempo_average, data[72:41]);
            compare_field("tempo_updates", 32'(want.tempo_updates), 32'(data[88:73]));
            compare_field("stopped", 32'(want.stopped), 32'(data[89]));
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'hFF;   // [0] pin_level, [7:1] zero
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [95:0]       m_tdata;            // [0] pressed, [24:1] hold_ticks,
                                           // [40:25] press_total,
                                           // [72:41] tempo_average,
                                           // [88:73] tempo_updates,
                                           // [89] stopped, [95:90] zero
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tempo_scoreboard   sb = new();
    int unsigned       ticks_sent   = 0;
    int unsigned       burst_left   = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       ready_step   = 0;

    switch_debounce_tap_tempo u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver cycles through four stall patterns, chosen by bits [9:8] of a step counter.
    always @(negedge aclk) begin
        ready_step++;
        case (ready_step[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= (ready_step[2:0] != 3'd0);
            2'd3: m_tready <= ready_step[4];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("switch_debounce_tap_tempo: mismatch");
                    $finish;
                end
            end
        end
    end

    task automatic send_tick(input logic pin);
        int unsigned gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pin};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic drive_run(input logic pin, input int unsigned n);
        repeat (n) send_tick(pin);
    endtask

    // Mostly well-formed taps with random hold and period, plus bounces,
    // silences long enough to stop the tempo, and long holds.
    task automatic play_taps(input int unsigned n_ticks, input int unsigned period_lo,
                             input int unsigned period_hi, input int unsigned hold_hi);
        int unsigned start, kind, hold, period;
        start = ticks_sent;
        while (ticks_sent - start < n_ticks) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                hold   = $urandom_range(1, hold_hi);
                period = $urandom_range(period_lo, period_hi);
                drive_run(1'b0, hold);
                drive_run(1'b1, (period > hold) ? period - hold : 1);
            end else if (kind < 17) begin
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
            end else if (kind < 19) begin
                drive_run(1'b1, $urandom_range(period_hi, 3 * period_hi));
            end else begin
                drive_run(1'b0, $urandom_range(period_hi, 2 * period_hi));
            end
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic apb_write(input swdb_reg_t which, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(which));
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.configure(which, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input logic [DELAY_W-1:0] delay,
                                  input logic [PERIOD_W-1:0] min_p,
                                  input logic [PERIOD_W-1:0] max_p,
                                  input logic [PERIOD_W-1:0] abort_p);
        settle();
        apb_write(REG_RELEASE_DELAY, 32'(delay));
        apb_write(REG_MIN_TAP, 32'(min_p));
        apb_write(REG_MAX_TAP, 32'(max_p));
        apb_write(REG_ABORT, 32'(abort_p));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Default settings: the tempo starts out stopped.
        drive_run(1'b1, 3);
        // The first press leaves the stopped state and clears the interval count.
        drive_run(1'b0, 3);
        // A press in the middle of the release countdown must not reload it.
        drive_run(1'b1, 4);
        drive_run(1'b0, 2);
        drive_run(1'b1, 9);
        // A second tap far below the minimum period leaves the average alone.
        drive_run(1'b0, 1);
        drive_run(1'b1, 3);

        apply_settings(16'd2, 24'd4, 24'd30, 24'd50);
        play_taps(150, 4, 35, 4);

        // Zero delay and the widest window: every interval counts.
        apply_settings(16'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        play_taps(150, 2, 20, 3);

        apply_settings(16'd5, 24'd10, 24'd60, 24'd90);
        play_taps(150, 8, 70, 6);

        apply_settings(16'd1, 24'd2, 24'd12, 24'd16);
        play_taps(110, 2, 18, 3);

        // Longest delay and an empty window with an immediate abort; kept last
        // because the switch cannot be released again within the run.
        apply_settings(16'hFFFF, 24'hFF_FFFF, 24'd0, 24'd0);
        play_taps(60, 2, 10, 3);

        settle();
        repeat (4) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("switch_debounce_tap_tempo: match");
        end else begin
            $display("switch_debounce_tap_tempo: mismatch");
        end
        $finish;
    end

endmodule
